@@ design/rcad_pkg.sv @@
// Package for rc_channel_average_deadband: pulse and per-channel entry types,
// register index codes and reset constants. No dependencies.
`timescale 1ns / 1ps

package rcad_pkg;

   localparam int PULSE_W   = 12;
   localparam int CH_W      = 3;
   localparam int SLOTS     = 3;
   localparam int POS_W     = 2;
   localparam int SUM_W     = PULSE_W + 2;
   localparam int CSR_IDX_W = 2;

   typedef logic [PULSE_W-1:0] pulse_type;
   typedef logic [POS_W-1:0]   pos_type;

   // register index codes
   localparam logic [CSR_IDX_W-1:0] CSR_FAILSAFE_ENABLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAILSAFE_THRESHOLD = 2'd1;

   localparam logic      FAILSAFE_ENABLE_RESET    = 1'b1;
   localparam pulse_type FAILSAFE_THRESHOLD_RESET = 12'd985;

   localparam pos_type LAST_POS = 2'd2;
   localparam int      BAND     = 3;
   localparam int      PULL_IN  = 2;
   localparam int      ROUNDING = 2;

   // one channel's state, kept as one memory word
   typedef struct packed {
      pulse_type [SLOTS-1:0] hist;
      pos_type               pos;
      pulse_type             filt;
   } entry_type;

endpackage

@@ design/rc_channel_average_deadband.sv @@
// Top level of rc_channel_average_deadband: per-channel moving average with
// a hysteresis deadband and failsafe gating. Depends on rcad_pkg.
`timescale 1ns / 1ps

// Filters raw RC pulse widths per receiver channel. Each req transaction
// (channel, raw_pulse, armed) yields exactly one rsp transaction carrying the
// channel, its filtered value after the sample and whether the sample passed
// failsafe gating (enabled, armed and pulse not above threshold rejects it).
// A passing sample is averaged with the channel's three stored samples,
// rounded as (sum+2)/4; the filtered value moves only when that mean leaves
// a +/-3 band around it, then lands 2 inside the band edge. Channels at or
// above CHANNELS report 0, not accepted, and touch no state.
// Rate: one transaction per cycle unless rsp_stall holds the flow; a req
// passes the modify stage, then the rsp register. All channel state sits in
// one CHANNELS-deep memory with a registered read: the accept edge reads,
// the modify stage modifies and writes back. A same-channel write landing on
// the read edge is forwarded. Per-entry valid flops make every channel read
// as zero after reset, so no clearing pass is needed. Stalls back up through
// a two-deep buffer (the modify stage and the rsp register). The user must
// write registers through the csr port (index 0 failsafe_enable, 1
// failsafe_threshold) only while idle, unenforced; csr_ready is always high.
module rc_channel_average_deadband
   import rcad_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   // sample transactions
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CH_W-1:0]      req_channel,
   input  logic [PULSE_W-1:0]   req_raw_pulse,
   input  logic                 req_armed,
   // result transactions
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CH_W-1:0]      rsp_out_channel,
   output logic [PULSE_W-1:0]   rsp_filtered_value,
   output logic                 rsp_accepted,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PULSE_W-1:0]   csr_wdata
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // config
   logic      fs_enable_ff;
   pulse_type fs_threshold_ff;

   // channel state memory and its reset-valid bits
   entry_type            mem [CHANNELS];
   entry_type            rd_data_ff;
   logic [CHANNELS-1:0]  ent_valid_ff;

   // modify stage
   logic            s1_valid_ff, s1_valid_in;
   logic [CH_W-1:0] s1_channel_ff;
   pulse_type       s1_raw_ff;
   logic            s1_armed_ff;
   logic            s1_in_range_ff;
   logic            s1_ent_valid_ff;
   logic            s1_fwd_ff;
   entry_type       s1_fwd_data_ff;

   // rsp register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0] rsp_channel_ff;
   pulse_type       rsp_value_ff;
   logic            rsp_accepted_ff;

   logic             req_accept;
   logic             s1_adv;
   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] s1_idx;
   logic             req_in_range;
   logic             wr_en;
   entry_type        cur;
   entry_type        wr_data;
   pos_type          new_pos;
   logic             good;
   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] sum_rnd;
   pulse_type        mean;
   logic [PULSE_W:0] mean_ext;
   logic [PULSE_W:0] cur_ext;
   pulse_type        out_value;

   // handshakes
   assign s1_adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = s1_valid_ff && !s1_adv;
   assign req_accept   = req_valid && !req_stall;
   assign csr_ready    = 1'b1;
   assign req_idx      = IDX_W'(req_channel);
   assign s1_idx       = IDX_W'(s1_channel_ff);
   assign req_in_range = int'(req_channel) < CHANNELS;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;
   end

   // modify: pick forwarded, stored or reset-zero entry
   always_comb begin
      if (s1_fwd_ff) begin
         cur = s1_fwd_data_ff;
      end else if (s1_ent_valid_ff) begin
         cur = rd_data_ff;
      end else begin
         cur = '0;
      end

      new_pos = (cur.pos >= LAST_POS) ? '0 : cur.pos + pos_type'(1);
      good    = !fs_enable_ff || (s1_raw_ff > fs_threshold_ff) || !s1_armed_ff;

      sum = SUM_W'(s1_raw_ff) + SUM_W'(cur.hist[0]) + SUM_W'(cur.hist[1])
          + SUM_W'(cur.hist[2]);
      sum_rnd  = sum + SUM_W'(ROUNDING);
      mean     = sum_rnd[SUM_W-1:2];
      mean_ext = {1'b0, mean};
      cur_ext  = {1'b0, cur.filt};

      wr_data     = cur;
      wr_data.pos = new_pos;
      if (good) begin
         // deadband: compare as mean+3 < cur so nothing goes negative
         if (mean_ext + (PULSE_W+1)'(BAND) < cur_ext) begin
            wr_data.filt = mean + pulse_type'(PULL_IN);
         end else if (mean_ext > cur_ext + (PULSE_W+1)'(BAND)) begin
            wr_data.filt = mean - pulse_type'(PULL_IN);
         end
         wr_data.hist[new_pos] = s1_raw_ff;
      end

      out_value = s1_in_range_ff ? wr_data.filt : '0;
      wr_en     = s1_valid_ff && s1_adv && s1_in_range_ff;
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_enable_ff    <= FAILSAFE_ENABLE_RESET;
         fs_threshold_ff <= FAILSAFE_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FAILSAFE_ENABLE:    fs_enable_ff    <= csr_wdata[0];
            CSR_FAILSAFE_THRESHOLD: fs_threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // state memory: registered read on accept, write-back from modify stage
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= mem[req_idx];
      end
      if (wr_en) begin
         mem[s1_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= '0;
      end else if (wr_en) begin
         ent_valid_ff[s1_idx] <= 1'b1;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // modify-stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_channel_ff   <= req_channel;
         s1_raw_ff       <= req_raw_pulse;
         s1_armed_ff     <= req_armed;
         s1_in_range_ff  <= req_in_range;
         s1_ent_valid_ff <= ent_valid_ff[req_idx];
         // write on this same edge is not yet visible in the read data
         s1_fwd_ff       <= wr_en && (s1_idx == req_idx);
         s1_fwd_data_ff  <= wr_data;
      end
   end

   // rsp payload
   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         rsp_channel_ff  <= s1_channel_ff;
         rsp_value_ff    <= out_value;
         rsp_accepted_ff <= s1_in_range_ff && good;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = rsp_channel_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_accepted       = rsp_accepted_ff;

`ifndef SYNTH
   // a stall upstream only ever comes from an occupied modify stage
   a_stall_needs_s1: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req_stall with empty modify stage");

   // write-back only when the modify stage hands its result on
   a_write_moves: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid_ff)
      else $error("state written without a result");

   // out-of-range channels report zero and never accepted
   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (int'(rsp_channel_ff) >= CHANNELS))
         |-> (!rsp_accepted_ff && (rsp_value_ff == '0)))
      else $error("out-of-range channel result not zero");

   // forwarding must be flagged whenever a same-channel write lands on the accept edge
   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      (req_accept && wr_en && (s1_idx == req_idx)) |=> s1_fwd_ff)
      else $error("missed same-channel forwarding");
`endif

endmodule
